[sv/wdpf_pkg.sv]
// Shared types, codes and fixed-point constants for the wall distance position fix.
// Depends on nothing; every other file of the block imports it.
package wdpf_pkg;

	// Sensor and wall codes as they arrive on the select inputs.
	typedef enum logic [1:0] {
		SENSOR_FRONT,
		SENSOR_REAR,
		SENSOR_LEFT,
		SENSOR_RIGHT
	} sensor_t;

	typedef enum logic [1:0] {
		WALL_TOP,
		WALL_BOTTOM,
		WALL_LEFT,
		WALL_RIGHT
	} wall_t;

	// Offset register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_FRONT_X,
		REG_FRONT_Y,
		REG_REAR_X,
		REG_REAR_Y,
		REG_LEFT_X,
		REG_LEFT_Y,
		REG_RIGHT_X,
		REG_RIGHT_Y
	} reg_index_t;

	// Field widths.
	localparam int OFFS_W  = 14;
	localparam int HEAD_W  = 15;
	localparam int RANGE_W = 15;
	localparam int POS_W   = 16;
	localparam int REM_W   = 13;
	localparam int TRIG_W  = 17;
	localparam int PROD_W  = 34;
	localparam int ACC_W   = 36;

	// Angle constants in 1/64 degree.
	localparam logic [HEAD_W-1:0] FULL_TURN   = 15'd23040;
	localparam logic [HEAD_W-1:0] Q_TURN      = 15'd5760;
	localparam logic [HEAD_W-1:0] HALF_TURN   = 15'd11520;
	localparam logic [HEAD_W-1:0] THREE_QTURN = 15'd17280;

	// Remainder to Q16 fraction: u = (r*512 + 22) / 45, by reciprocal and one correction.
	localparam int              UQ_SHIFT    = 9;
	localparam int              NUM_W       = REM_W + UQ_SHIFT;
	localparam logic [NUM_W-1:0] UQ_BIAS    = 22'd22;
	localparam logic [6:0]      DIV_N       = 7'd45;
	localparam logic [16:0]     RECIP45     = 17'd93206;
	localparam int              RECIP_SHIFT = 22;
	localparam int              RECIP_W     = NUM_W + 17;

	// Quarter-wave sine polynomial, Q16.
	localparam logic [TRIG_W-1:0] SIN_A = 17'd102943;
	localparam logic [TRIG_W-1:0] SIN_B = 17'd42047;
	localparam logic [TRIG_W-1:0] SIN_C = 17'd4640;
	localparam logic [TRIG_W-1:0] U_ONE = 17'd65536;
	localparam int                QS_LAT = 5;

	// Result scaling: Q24 sum back to Q8 with round half up.
	localparam int WALL_SHIFT = 24;
	localparam int ROUND_HALF = 32768;
	localparam int FRAC_SHIFT = 16;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		logic                     present;
		logic                     is_x;
		logic                     wall_neg;
		logic [1:0]               quad_h;
		logic [1:0]               quad_t;
		logic [REM_W-1:0]         rem;
		logic [RANGE_W-1:0]       range_val;
		logic signed [OFFS_W-1:0] x_off;
		logic signed [OFFS_W-1:0] y_off;
	} item_t;

	typedef struct packed {
		logic  vld;
		item_t item;
	} qitem_t;

	typedef struct packed {
		logic              we;
		reg_index_t        index;
		logic [OFFS_W-1:0] data;
	} cfg_wr_t;

	// Quarter turns that the wall adds to the heading.
	function automatic logic [1:0] wall_quarters(wall_t wall);
		logic [1:0] q;
		unique case (wall)
			WALL_TOP:    q = 2'd3;
			WALL_BOTTOM: q = 2'd3;
			WALL_LEFT:   q = 2'd1;
			WALL_RIGHT:  q = 2'd1;
			default:     q = 2'd0;
		endcase
		return q;
	endfunction

	// Quarter turns that the sensor mounting adds to the heading.
	function automatic logic [1:0] sensor_quarters(sensor_t sensor);
		logic [1:0] q;
		unique case (sensor)
			SENSOR_FRONT: q = 2'd0;
			SENSOR_REAR:  q = 2'd2;
			SENSOR_LEFT:  q = 2'd1;
			SENSOR_RIGHT: q = 2'd3;
			default:      q = 2'd0;
		endcase
		return q;
	endfunction

endpackage

[sv/wdpf_front.sv]
// Front end: offset registers, item acceptance and classification.
// Depends on wdpf_pkg for the item, configuration and code types.
module wdpf_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wdpf_pkg::cfg_wr_t                  cfg,
	input  logic                               start,
	input  logic                               q_full,
	input  logic [1:0]                         sensor_select,
	input  logic [1:0]                         wall_select,
	input  logic [wdpf_pkg::HEAD_W-1:0]        heading,
	input  logic [wdpf_pkg::RANGE_W-1:0]       range_reading,
	input  logic                               reading_present,
	output logic                               busy,
	output logic                               push,
	output wdpf_pkg::item_t                    item
);
	import wdpf_pkg::*;

	logic signed [OFFS_W-1:0] x_off_q [4];
	logic signed [OFFS_W-1:0] y_off_q [4];

	sensor_t           sensor;
	wall_t             wall;
	logic [HEAD_W-1:0] h_red;
	logic [HEAD_W-1:0] base;
	logic [HEAD_W-1:0] h_rem;
	logic [1:0]        quad;

	// Offset registers, one pair per sensor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				x_off_q[i] <= '0;
				y_off_q[i] <= '0;
			end
		end else if (cfg.we) begin
			unique case (cfg.index)
				REG_FRONT_X: x_off_q[SENSOR_FRONT] <= $signed(cfg.data);
				REG_FRONT_Y: y_off_q[SENSOR_FRONT] <= $signed(cfg.data);
				REG_REAR_X:  x_off_q[SENSOR_REAR]  <= $signed(cfg.data);
				REG_REAR_Y:  y_off_q[SENSOR_REAR]  <= $signed(cfg.data);
				REG_LEFT_X:  x_off_q[SENSOR_LEFT]  <= $signed(cfg.data);
				REG_LEFT_Y:  y_off_q[SENSOR_LEFT]  <= $signed(cfg.data);
				REG_RIGHT_X: x_off_q[SENSOR_RIGHT] <= $signed(cfg.data);
				REG_RIGHT_Y: y_off_q[SENSOR_RIGHT] <= $signed(cfg.data);
				default:     x_off_q[SENSOR_FRONT] <= x_off_q[SENSOR_FRONT];
			endcase
		end
	end

	// An item is taken whenever the queue has room.
	assign busy = q_full;
	assign push = start && !q_full;

	assign sensor = sensor_t'(sensor_select);
	assign wall   = wall_t'(wall_select);

	// Wrap the heading once, then split it into quadrant and remainder.
	always_comb begin
		h_red = (heading >= FULL_TURN) ? (heading - FULL_TURN) : heading;
		priority if (h_red >= THREE_QTURN) begin
			quad = 2'd3;
			base = THREE_QTURN;
		end else if (h_red >= HALF_TURN) begin
			quad = 2'd2;
			base = HALF_TURN;
		end else if (h_red >= Q_TURN) begin
			quad = 2'd1;
			base = Q_TURN;
		end else begin
			quad = 2'd0;
			base = '0;
		end
		h_rem = h_red - base;
	end

	// Classified item for the queue.
	always_comb begin
		item.present   = reading_present;
		item.is_x      = (wall == WALL_LEFT) || (wall == WALL_RIGHT);
		item.wall_neg  = (wall == WALL_BOTTOM) || (wall == WALL_LEFT);
		item.quad_h    = quad;
		item.quad_t    = quad + wall_quarters(wall) + sensor_quarters(sensor);
		item.rem       = h_rem[REM_W-1:0];
		item.range_val = range_reading;
		item.x_off     = x_off_q[sensor];
		item.y_off     = y_off_q[sensor];
	end

endmodule

[sv/wdpf_queue.sv]
// Two-entry queue that decouples the front end from the arithmetic back end.
// Depends on wdpf_pkg for the item types.
module wdpf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wdpf_pkg::item_t  push_item,
	input  logic             pop,
	output logic             full,
	output wdpf_pkg::qitem_t head
);
	import wdpf_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign head.vld  = (cnt_q != 2'd0);
	assign head.item = mem_q[rd_ptr_q];

endmodule

[sv/wdpf_qsine.sv]
// Five-stage pipelined quarter-wave sine polynomial, Q16 in and out.
// Depends on wdpf_pkg for widths and polynomial coefficients.
module wdpf_qsine (
	input  logic                        clk,
	input  logic [wdpf_pkg::TRIG_W-1:0] u,
	output logic [wdpf_pkg::TRIG_W-1:0] s
);
	import wdpf_pkg::*;

	logic [TRIG_W-1:0] u_s1, u2_s1, u2_s2, u3_s2, u5_s3, s_s5;
	logic [PROD_W-1:0] pa_s1, pa_s2, pa_s3, pb_s3, pc_s4;
	logic signed [ACC_W-1:0] diff_s4;

	logic [PROD_W-1:0] sq_c, cu_c, fi_c, pa_c, pb_c, pc_c;
	logic signed [ACC_W-1:0] diff_c, acc_c;
	logic [TRIG_W-1:0] clamp_c;

	// Powers of u and the polynomial terms, one multiply deep per stage.
	assign sq_c = PROD_W'(u) * PROD_W'(u);
	assign pa_c = PROD_W'(u) * PROD_W'(SIN_A);
	assign cu_c = PROD_W'(u2_s1) * PROD_W'(u_s1);
	assign fi_c = PROD_W'(u3_s2) * PROD_W'(u2_s2);
	assign pb_c = PROD_W'(u3_s2) * PROD_W'(SIN_B);
	assign pc_c = PROD_W'(u5_s3) * PROD_W'(SIN_C);

	assign diff_c = $signed(ACC_W'(pa_s3)) - $signed(ACC_W'(pb_s3));
	assign acc_c  = diff_s4 + $signed(ACC_W'(pc_s4));

	// Floor to Q16 and clamp to the unit range.
	always_comb begin
		if (acc_c[ACC_W-1]) begin
			clamp_c = '0;
		end else if (acc_c[ACC_W-1:16] > 20'(U_ONE)) begin
			clamp_c = U_ONE;
		end else begin
			clamp_c = acc_c[TRIG_W+15:16];
		end
	end

	always_ff @(posedge clk) begin
		u_s1    <= u;
		u2_s1   <= sq_c[32:16];
		pa_s1   <= pa_c;
		u2_s2   <= u2_s1;
		u3_s2   <= cu_c[32:16];
		pa_s2   <= pa_s1;
		u5_s3   <= fi_c[32:16];
		pb_s3   <= pb_c;
		pa_s3   <= pa_s2;
		diff_s4 <= diff_c;
		pc_s4   <= pc_c;
		s_s5    <= clamp_c;
	end

	assign s = s_s5;

endmodule

[sv/wdpf_back.sv]
// Back end: heading fraction, sine and cosine, projection sum, rounding and saturation.
// Depends on wdpf_pkg and instantiates wdpf_qsine twice.
module wdpf_back #(
	parameter int FIELD_HALF = 70
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wdpf_pkg::qitem_t                  q_in,
	output logic                              done,
	output logic signed [wdpf_pkg::POS_W-1:0] axis_position,
	output logic                              axis_is_x,
	output logic                              result_valid
);
	import wdpf_pkg::*;

	localparam logic signed [ACC_W-1:0] WALL_C = ACC_W'(FIELD_HALF) <<< WALL_SHIFT;
	localparam int SUM_HI_W = ACC_W - FRAC_SHIFT;

	typedef struct packed {
		logic signed [TRIG_W:0] s;
		logic signed [TRIG_W:0] c;
	} trig_pair_t;

	// Sine and cosine of a heading in the given quadrant.
	function automatic trig_pair_t map_quad(logic [1:0] quad, logic signed [TRIG_W:0] sp,
		logic signed [TRIG_W:0] cp);
		trig_pair_t t;
		unique case (quad)
			2'd0: begin
				t.s = sp;
				t.c = cp;
			end
			2'd1: begin
				t.s = cp;
				t.c = -sp;
			end
			2'd2: begin
				t.s = -sp;
				t.c = -cp;
			end
			default: begin
				t.s = -cp;
				t.c = sp;
			end
		endcase
		return t;
	endfunction

	logic                   vld_s1, vld_s2, vld_s8, vld_s9, vld_s10, vld_s11;
	item_t                  item_s1, item_s2, item_s8, item_s9, item_s10;
	logic [RECIP_W-1:0]     prod_s1;
	logic [TRIG_W-1:0]      u_s2, v_s2;
	logic                   vld_dly_q [QS_LAT];
	item_t                  item_dly_q [QS_LAT];
	logic signed [TRIG_W:0] cr_s8, cx_s8, cy_s8;
	logic signed [PROD_W-1:0] pr_s9;
	logic signed [31:0]     px_s9, py_s9;
	logic signed [ACC_W-1:0] sum_s10;
	logic signed [POS_W-1:0] pos_s11;
	logic                   is_x_s11, present_s11;

	logic [NUM_W-1:0]       n0_c, n1_c;
	logic [TRIG_W-1:0]      q0_c, u_c;
	logic [NUM_W:0]         rem45_c;
	logic [TRIG_W-1:0]      sin_u, sin_v;
	trig_pair_t             th_c, tt_c;
	logic signed [RANGE_W:0] rng_c;
	logic signed [ACC_W-1:0] sum_c, t_c;
	logic signed [SUM_HI_W-1:0] hi_c;
	logic signed [POS_W-1:0] sat_c;

	// Valid chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			for (int i = 0; i < QS_LAT; i++) begin
				vld_dly_q[i] <= 1'b0;
			end
		end else begin
			vld_s1       <= q_in.vld;
			vld_s2       <= vld_s1;
			vld_dly_q[0] <= vld_s2;
			for (int i = 1; i < QS_LAT; i++) begin
				vld_dly_q[i] <= vld_dly_q[i-1];
			end
			vld_s8  <= vld_dly_q[QS_LAT-1];
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	// Remainder to Q16 fraction: reciprocal multiply, then one correction step.
	assign n0_c    = {q_in.item.rem, UQ_SHIFT'(0)} + UQ_BIAS;
	assign n1_c    = {item_s1.rem, UQ_SHIFT'(0)} + UQ_BIAS;
	assign q0_c    = prod_s1[RECIP_W-1:RECIP_SHIFT];
	assign rem45_c = (NUM_W+1)'(n1_c) - (NUM_W+1)'(q0_c) * (NUM_W+1)'(DIV_N);
	assign u_c     = (rem45_c >= (NUM_W+1)'(DIV_N)) ? (q0_c + 17'd1) : q0_c;

	// Sine of the fraction and of its complement.
	wdpf_qsine u_sin (
		.clk (clk),
		.u   (u_s2),
		.s   (sin_u)
	);

	wdpf_qsine u_cos (
		.clk (clk),
		.u   (v_s2),
		.s   (sin_v)
	);

	// Quadrant mapping and coefficient selection for the chosen axis.
	assign th_c = map_quad(item_dly_q[QS_LAT-1].quad_h, $signed({1'b0, sin_u}),
		$signed({1'b0, sin_v}));
	assign tt_c = map_quad(item_dly_q[QS_LAT-1].quad_t, $signed({1'b0, sin_u}),
		$signed({1'b0, sin_v}));

	assign rng_c = $signed({1'b0, item_s8.range_val});

	// Projection sum with the wall coordinate.
	assign sum_c = (item_s9.wall_neg ? -WALL_C : WALL_C) + ACC_W'(pr_s9) + ACC_W'(px_s9)
		+ ACC_W'(py_s9);

	// Round half up, then saturate to the output range.
	assign t_c  = sum_s10 + ACC_W'(ROUND_HALF);
	assign hi_c = t_c[ACC_W-1:FRAC_SHIFT];

	always_comb begin
		priority if (hi_c > SUM_HI_W'(32767)) begin
			sat_c = 16'sh7FFF;
		end else if (hi_c < -SUM_HI_W'(32768)) begin
			sat_c = 16'sh8000;
		end else begin
			sat_c = hi_c[POS_W-1:0];
		end
	end

	// Payload pipeline.
	always_ff @(posedge clk) begin
		item_s1       <= q_in.item;
		prod_s1       <= RECIP_W'(n0_c) * RECIP_W'(RECIP45);
		item_s2       <= item_s1;
		u_s2          <= u_c;
		v_s2          <= U_ONE - u_c;
		item_dly_q[0] <= item_s2;
		for (int i = 1; i < QS_LAT; i++) begin
			item_dly_q[i] <= item_dly_q[i-1];
		end
		item_s8 <= item_dly_q[QS_LAT-1];
		if (item_dly_q[QS_LAT-1].is_x) begin
			cr_s8 <= tt_c.c;
			cx_s8 <= -th_c.c;
			cy_s8 <= -th_c.s;
		end else begin
			cr_s8 <= tt_c.s;
			cx_s8 <= th_c.s;
			cy_s8 <= -th_c.c;
		end
		item_s9     <= item_s8;
		pr_s9       <= PROD_W'(cr_s8) * PROD_W'(rng_c);
		px_s9       <= 32'(cx_s8) * 32'(item_s8.x_off);
		py_s9       <= 32'(cy_s8) * 32'(item_s8.y_off);
		item_s10    <= item_s9;
		sum_s10     <= sum_c;
		pos_s11     <= item_s10.present ? sat_c : '0;
		is_x_s11    <= item_s10.present && item_s10.is_x;
		present_s11 <= item_s10.present;
	end

	assign done          = vld_s11;
	assign axis_position = pos_s11;
	assign axis_is_x     = is_x_s11;
	assign result_valid  = present_s11;

endmodule

[sv/wall_distance_position_fix.sv]
// Top level of the wall distance position fix: front end, queue and arithmetic back end.
// Depends on wdpf_pkg, wdpf_front, wdpf_queue, wdpf_qsine and wdpf_back.
//
//   channel   handshake            payload
//   item in   start / busy         sensor_select, wall_select, heading, range_reading,
//                                  reading_present
//   result    done (one cycle)     axis_position, axis_is_x, result_valid
//   config    cfg_we               cfg_index, cfg_data
//
// One item is taken per clock cycle. Its result passes the queue, the fraction stages,
// the sine pipeline and the coefficient, product, sum and output registers; the depth is
// set by four dependent multiplies in the sine pipeline and the projection multipliers.
// Reset clears the offset registers to zero, empties the queue and drops items in flight.
// The back end drains the queue every cycle, so busy does not rise in use; the
// receiver cannot hold results off.
module wall_distance_position_fix #(
	parameter int FIELD_HALF = 70
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         sensor_select,
	input  logic [1:0]                         wall_select,
	input  logic [wdpf_pkg::HEAD_W-1:0]        heading,
	input  logic [wdpf_pkg::RANGE_W-1:0]       range_reading,
	input  logic                               reading_present,
	input  logic                               cfg_we,
	input  logic [2:0]                         cfg_index,
	input  logic [wdpf_pkg::OFFS_W-1:0]        cfg_data,
	output logic                               done,
	output logic signed [wdpf_pkg::POS_W-1:0]  axis_position,
	output logic                               axis_is_x,
	output logic                               result_valid
);
	import wdpf_pkg::*;

	cfg_wr_t cfg;
	logic    push;
	logic    q_full;
	item_t   front_item;
	qitem_t  q_head;

	assign cfg.we    = cfg_we;
	assign cfg.index = reg_index_t'(cfg_index);
	assign cfg.data  = cfg_data;

	// Acceptance and classification.
	wdpf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.start           (start),
		.q_full          (q_full),
		.sensor_select   (sensor_select),
		.wall_select     (wall_select),
		.heading         (heading),
		.range_reading   (range_reading),
		.reading_present (reading_present),
		.busy            (busy),
		.push            (push),
		.item            (front_item)
	);

	// Queue between the two halves; the back end takes the head whenever it is there.
	wdpf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (q_head.vld),
		.full      (q_full),
		.head      (q_head)
	);

	// Arithmetic pipeline.
	wdpf_back #(
		.FIELD_HALF (FIELD_HALF)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_in          (q_head),
		.done          (done),
		.axis_position (axis_position),
		.axis_is_x     (axis_is_x),
		.result_valid  (result_valid)
	);

`ifndef SYNTHESIS
	// A result comes only from an item that left the queue earlier.
	a_done_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(q_head.vld, 11))
		else $error("result without a matching item from the queue");

	// The back end drains the queue every cycle, so it never fills.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("queue filled although the back end never stalls");

	// A missing reading yields an all-zero result.
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result_valid) |-> (axis_position == '0 && !axis_is_x))
		else $error("result without a reading is not zero");
`endif

endmodule

[tb/wall_distance_position_fix_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for wall_distance_position_fix: drives range readings and
// offset writes, predicts every position fix in SystemVerilog and compares it on arrival.
// Depends on wdpf_pkg and wall_distance_position_fix.
module wall_distance_position_fix_test;
	import wdpf_pkg::*;

	localparam int FIELD_HALF      = 70;
	localparam int HALF_PERIOD     = 10;
	localparam int RESET_CYCLES    = 6;
	localparam int MAX_GAP         = 18;
	localparam int RESULT_LATENCY  = 12;
	localparam int DRAIN_CYCLES    = 2 * RESULT_LATENCY;
	// Longest legal quiet stretch is a full sender gap plus the pipeline drain and a few
	// register writes; the limit is many times that.
	localparam int WATCHDOG_LIMIT  = 500;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 104;
	localparam int NUM_OFFSETS     = 8;
	localparam int TURN_UNITS      = 23040;
	localparam int QUARTER_UNITS   = 5760;
	localparam int HEADING_MAX     = 32767;
	localparam int RANGE_MAX       = 32767;
	localparam logic signed [OFFS_W-1:0] OFFSET_MIN = -14'sd8192;
	localparam logic signed [OFFS_W-1:0] OFFSET_MAX = 14'sd8191;

	typedef enum {OFFS_RANDOM, OFFS_ZERO, OFFS_MIN, OFFS_MAX, OFFS_MIXED} offset_mode_t;

	typedef struct packed {
		logic signed [17:0] sin_q16;
		logic signed [17:0] cos_q16;
	} trig_pair_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position;
		logic                    is_x;
		logic                    valid;
	} fix_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [1:0]                sensor_select;
	logic [1:0]                wall_select;
	logic [HEAD_W-1:0]         heading;
	logic [RANGE_W-1:0]        range_reading;
	logic                      reading_present;
	logic                      cfg_we;
	logic [2:0]                cfg_index;
	logic [OFFS_W-1:0]         cfg_data;
	logic                      done;
	logic signed [POS_W-1:0]   axis_position;
	logic                      axis_is_x;
	logic                      result_valid;

	logic signed [OFFS_W-1:0]  mount_offset [NUM_OFFSETS];
	fix_t                      pending_fixes [$];
	int                        fail_count = 0;
	int                        quiet_cycles = 0;
	logic                      no_idle;

	wall_distance_position_fix #(
		.FIELD_HALF(FIELD_HALF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sensor_select(sensor_select),
		.wall_select(wall_select),
		.heading(heading),
		.range_reading(range_reading),
		.reading_present(reading_present),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.axis_position(axis_position),
		.axis_is_x(axis_is_x),
		.result_valid(result_valid)
	);

	always #HALF_PERIOD clk = ~clk;

	// Quarter-wave sine polynomial on a Q16 fraction of a right angle.
	function automatic logic [16:0] quarter_sine(logic [16:0] u);
		longint uu, u2, u3, u5, acc;
		uu = u;
		u2 = (uu * uu) >>> 16;
		u3 = (u2 * uu) >>> 16;
		u5 = (u3 * u2) >>> 16;
		acc = 102943 * uu - 42047 * u3 + 4640 * u5;
		if (acc < 0)
			acc = 0;
		acc = acc >>> 16;
		if (acc > 65536)
			acc = 65536;
		return acc[16:0];
	endfunction

	// Sine and cosine of a reduced heading turned by some quarter turns, Q16.
	function automatic trig_pair_t heading_trig(int unsigned h, int unsigned turns);
		int unsigned quad, rem, u;
		logic signed [17:0] sv, cv;
		trig_pair_t tp;
		quad = (h / QUARTER_UNITS + turns) % 4;
		rem = h % QUARTER_UNITS;
		u = (rem * 65536 + QUARTER_UNITS / 2) / QUARTER_UNITS;
		sv = quarter_sine(u[16:0]);
		cv = quarter_sine(17'(65536 - u));
		case (quad)
			0: begin
				tp.sin_q16 = sv;
				tp.cos_q16 = cv;
			end
			1: begin
				tp.sin_q16 = cv;
				tp.cos_q16 = -sv;
			end
			2: begin
				tp.sin_q16 = -sv;
				tp.cos_q16 = -cv;
			end
			default: begin
				tp.sin_q16 = -cv;
				tp.cos_q16 = sv;
			end
		endcase
		return tp;
	endfunction

	// Robot coordinate that one reading gives under the current mounting offsets.
	function automatic fix_t predict_fix(sensor_t sensor, wall_t wall, logic [HEAD_W-1:0] hdg,
			logic [RANGE_W-1:0] rng, logic present);
		fix_t fix;
		int unsigned h, turns;
		longint xo, yo, r, acc, pos, bs, bc, ts, tc;
		trig_pair_t body, beam;
		fix = '0;
		if (!present)
			return fix;
		h = hdg % TURN_UNITS;
		xo = mount_offset[2 * sensor];
		yo = mount_offset[2 * sensor + 1];
		r = rng;
		case (wall)
			WALL_TOP, WALL_BOTTOM: turns = 3;
			default:               turns = 1;
		endcase
		case (sensor)
			SENSOR_FRONT: turns = turns + 0;
			SENSOR_REAR:  turns = turns + 2;
			SENSOR_LEFT:  turns = turns + 1;
			default:      turns = turns + 3;
		endcase
		body = heading_trig(h, 0);
		beam = heading_trig(h, turns);
		bs = body.sin_q16;
		bc = body.cos_q16;
		ts = beam.sin_q16;
		tc = beam.cos_q16;
		acc = longint'(FIELD_HALF) <<< 24;
		if (wall == WALL_BOTTOM || wall == WALL_LEFT)
			acc = -acc;
		fix.is_x = (wall == WALL_LEFT || wall == WALL_RIGHT);
		if (fix.is_x)
			acc = acc + tc * r - bc * xo - bs * yo;
		else
			acc = acc + ts * r + bs * xo - bc * yo;
		// Round half up from Q24 to Q8, then clamp to the output range.
		pos = (acc + 32768) >>> 16;
		if (pos > 32767)
			pos = 32767;
		if (pos < -32768)
			pos = -32768;
		fix.position = pos[15:0];
		fix.valid = 1'b1;
		return fix;
	endfunction

	// Every accepted item queues the fix it should produce.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			pending_fixes.push_back(predict_fix(sensor_t'(sensor_select), wall_t'(wall_select),
				heading, range_reading, reading_present));
	end

	// Each strobed result is compared with the oldest queued fix.
	always @(posedge clk) begin
		fix_t want;
		if (arst_n && done) begin
			if (pending_fixes.size() == 0) begin
				$error("result strobe with no item outstanding: axis_position %0d",
					axis_position);
				fail_count++;
			end else begin
				want = pending_fixes.pop_front();
				if (axis_position !== want.position) begin
					$error("axis_position: expected %0d, got %0d", $signed(want.position),
						axis_position);
					fail_count++;
				end
				if (axis_is_x !== want.is_x) begin
					$error("axis_is_x: expected %0d, got %0d", want.is_x, axis_is_x);
					fail_count++;
				end
				if (result_valid !== want.valid) begin
					$error("result_valid: expected %0d, got %0d", want.valid, result_valid);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on stretches where nothing moves on any port.
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Present one item, after a random gap unless no_idle is set, and hold it until the block takes it.
	task automatic send_reading(sensor_t sensor, wall_t wall, logic [HEAD_W-1:0] hdg,
			logic [RANGE_W-1:0] rng, logic present);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sensor_select <= sensor;
		wall_select <= wall;
		heading <= hdg;
		range_reading <= rng;
		reading_present <= present;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Stop sending and let every outstanding fix come back before touching registers.
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_fixes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_offset(reg_index_t idx, logic signed [OFFS_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		mount_offset[idx] = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all_offsets(offset_mode_t mode);
		logic signed [OFFS_W-1:0] value;
		for (int i = 0; i < NUM_OFFSETS; i++) begin
			case (mode)
				OFFS_ZERO:  value = '0;
				OFFS_MIN:   value = OFFSET_MIN;
				OFFS_MAX:   value = OFFSET_MAX;
				OFFS_MIXED: value = $urandom_range(0, 1) ? OFFSET_MAX : OFFSET_MIN;
				default:    value = OFFS_W'($urandom_range(0, 16383));
			endcase
			write_offset(reg_index_t'(i), value);
		end
	endtask

	// Random item, weighted toward quadrant edges, wrapped headings and range extremes.
	task automatic send_random_reading();
		logic [HEAD_W-1:0] hdg;
		logic [RANGE_W-1:0] rng;
		case ($urandom_range(0, 9))
			0: hdg = HEAD_W'($urandom_range(0, 3) * QUARTER_UNITS);
			1: hdg = HEAD_W'($urandom_range(0, 3) * QUARTER_UNITS + QUARTER_UNITS - 1);
			2: hdg = HEAD_W'($urandom_range(TURN_UNITS, HEADING_MAX));
			default: hdg = HEAD_W'($urandom_range(0, TURN_UNITS - 1));
		endcase
		case ($urandom_range(0, 9))
			0: rng = '0;
			1: rng = RANGE_W'(RANGE_MAX);
			2: rng = RANGE_W'($urandom_range(0, 255));
			default: rng = RANGE_W'($urandom_range(0, RANGE_MAX));
		endcase
		send_reading(sensor_t'($urandom_range(0, 3)), wall_t'($urandom_range(0, 3)), hdg, rng,
			$urandom_range(0, 9) != 0);
	endtask

	// A missing reading must clear every result field, whatever the other inputs hold.
	task automatic test_no_reading();
		send_reading(SENSOR_FRONT, WALL_TOP, '0, '0, 1'b0);
		send_reading(SENSOR_RIGHT, WALL_RIGHT, HEAD_W'(HEADING_MAX), RANGE_W'(RANGE_MAX), 1'b0);
		send_reading(SENSOR_LEFT, WALL_BOTTOM, 15'd12345, 15'd20000, 1'b0);
	endtask

	// Every sensor against two different walls, with random offsets per sensor.
	task automatic test_sensor_wall_pairs();
		wait_idle();
		write_all_offsets(OFFS_RANDOM);
		for (int s = 0; s < 4; s++) begin
			send_reading(sensor_t'(s), wall_t'(s), HEAD_W'($urandom_range(0, TURN_UNITS - 1)),
				RANGE_W'($urandom_range(0, RANGE_MAX)), 1'b1);
			send_reading(sensor_t'(s), wall_t'(3 - s),
				HEAD_W'($urandom_range(0, TURN_UNITS - 1)),
				RANGE_W'($urandom_range(0, RANGE_MAX)), 1'b1);
		end
	endtask

	// Heading at zero, on either side of a quadrant edge, at the turn and past it.
	task automatic test_heading_extremes();
		send_reading(SENSOR_FRONT, WALL_RIGHT, '0, 15'd1000, 1'b1);
		send_reading(SENSOR_REAR, WALL_TOP, HEAD_W'(QUARTER_UNITS - 1), 15'd2000, 1'b1);
		send_reading(SENSOR_LEFT, WALL_LEFT, HEAD_W'(QUARTER_UNITS), 15'd3000, 1'b1);
		send_reading(SENSOR_RIGHT, WALL_BOTTOM, HEAD_W'(TURN_UNITS - 1), 15'd4000, 1'b1);
		send_reading(SENSOR_FRONT, WALL_TOP, HEAD_W'(TURN_UNITS), 15'd5000, 1'b1);
		send_reading(SENSOR_REAR, WALL_RIGHT, HEAD_W'(HEADING_MAX), 15'd6000, 1'b1);
	endtask

	// Full range along the wall normal with extreme offsets drives both saturation limits.
	task automatic test_saturation();
		wait_idle();
		write_all_offsets(OFFS_MIN);
		send_reading(SENSOR_FRONT, WALL_RIGHT, HEAD_W'(3 * QUARTER_UNITS), RANGE_W'(RANGE_MAX),
			1'b1);
		send_reading(SENSOR_FRONT, WALL_LEFT, HEAD_W'(QUARTER_UNITS), RANGE_W'(RANGE_MAX), 1'b1);
		wait_idle();
		write_all_offsets(OFFS_MAX);
		send_reading(SENSOR_REAR, WALL_TOP, '0, RANGE_W'(RANGE_MAX), 1'b1);
		send_reading(SENSOR_LEFT, WALL_BOTTOM, HEAD_W'(HEADING_MAX), RANGE_W'(RANGE_MAX), 1'b1);
	endtask

	// Phases of random items, each under a fresh set of mounting offsets.
	task automatic test_random_traffic();
		offset_mode_t mode;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: mode = OFFS_ZERO;
				1: mode = OFFS_MIXED;
				2: mode = OFFS_MAX;
				3: mode = OFFS_MIN;
				default: mode = OFFS_RANDOM;
			endcase
			write_all_offsets(mode);
			no_idle = (phase % 3 == 2);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_random_reading();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		sensor_select = '0;
		wall_select = '0;
		heading = '0;
		range_reading = '0;
		reading_present = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		no_idle = 1'b0;
		for (int i = 0; i < NUM_OFFSETS; i++)
			mount_offset[i] = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_no_reading();
		test_sensor_wall_pairs();
		test_heading_extremes();
		test_saturation();
		test_random_traffic();
		wait_idle();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[files.f]
sv/wdpf_pkg.sv
sv/wdpf_front.sv
sv/wdpf_queue.sv
sv/wdpf_qsine.sv
sv/wdpf_back.sv
sv/wall_distance_position_fix.sv
tb/wall_distance_position_fix_test.sv
